>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, masked while reset is held
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// clocked assertion that also holds across reset
`define ASSERT_CLK_RST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

>>> hw/rtl/bsm_pkg.sv
// ----------------------------------------------------------------------------
// bsm_pkg
// types and constants for the bounded substring matcher
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bsm_pkg;

    localparam int NEEDLE_W   = 64;
    localparam int LENGTH_W   = 4;
    localparam int LIMIT_W    = 16;
    localparam int COUNT_W    = 17;
    localparam int CFG_IDX_W  = 8;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_BYTES  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_LENGTH = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_LIMIT  = 8'd2;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_string;
    } t_in_word;

    typedef struct packed {
        logic                found;
        logic [LIMIT_W-1:0]  match_position;
    } t_out_word;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctrl;

endpackage

`default_nettype wire

>>> hw/rtl/bsm_cell.sv
// ----------------------------------------------------------------------------
// bsm_cell
// one window slot: holds a byte, passes it on, compares the incoming byte
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsm_cell (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire bsm_pkg::t_cell_ctrl i_ctrl,
    input  wire logic [7:0]         i_byte,
    input  wire logic [7:0]         i_needle_byte,
    input  wire logic               i_active,
    output logic [7:0]              o_byte,
    output logic                    o_hit
);

    logic [7:0] r_byte;
    logic [7:0] n_byte;

    always_comb begin
        n_byte = r_byte;
        if (i_ctrl.clear) begin
            n_byte = 8'h00;
        end else if (i_ctrl.shift) begin
            n_byte = i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= 8'h00;
        end else begin
            r_byte <= n_byte;
        end
    end

    // compare against the byte arriving now, i.e. the window after the shift
    assign o_hit  = !i_active || (i_byte == i_needle_byte);
    assign o_byte = r_byte;

endmodule

`default_nettype wire

>>> hw/rtl/bounded_substring_matcher.sv
// ----------------------------------------------------------------------------
// bounded_substring_matcher
// streaming search for a short needle within a bounded haystack prefix
// ----------------------------------------------------------------------------
// Takes one haystack byte per clock cycle, back to back, with a terminator word
// closing each string. The last bytes sit in a row of MAX_NEEDLE cells that
// shift by one slot per accepted byte until a result is reported; every active
// cell compares its incoming byte with its needle byte in the same cycle, so
// the rate of one word per cycle is set by the combinational compare across the
// row and the position counter. A result lands in the output register in the
// cycle after its word is accepted; the input stalls only while that register
// is full and the output side stalls. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bounded_substring_matcher #(
    parameter int MAX_NEEDLE = 8
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire bsm_pkg::t_in_word                  i_in_word,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output bsm_pkg::t_out_word                      o_out_word,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [bsm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [bsm_pkg::NEEDLE_W-1:0]       i_cfg_data
);

    localparam int LW = bsm_pkg::LENGTH_W;
    localparam int CW = bsm_pkg::COUNT_W;

    logic [bsm_pkg::NEEDLE_W-1:0] r_needle;
    logic [LW-1:0]                r_length;
    logic [bsm_pkg::LIMIT_W-1:0]  r_limit;
    logic [CW-1:0]                r_count;
    logic [CW-1:0]                n_count;
    logic                         r_reported;
    logic                         n_reported;
    logic                         r_out_valid;
    logic                         n_out_valid;
    bsm_pkg::t_out_word           r_out_word;
    bsm_pkg::t_out_word           n_out_word;

    logic [LW-1:0]        used_len;
    logic                 in_acc;
    logic                 out_acc;
    logic                 byte_step;
    logic                 empty_hit;
    logic                 term_res;
    logic                 match;
    logic [CW-1:0]        count_inc;
    bsm_pkg::t_cell_ctrl  cell_ctrl;
    logic [7:0]           chain [MAX_NEEDLE+1];
    logic [MAX_NEEDLE-1:0] hits;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_needle <= '0;
            r_length <= '0;
            r_limit  <= bsm_pkg::LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                bsm_pkg::CFG_NEEDLE_BYTES:  r_needle <= i_cfg_data;
                bsm_pkg::CFG_NEEDLE_LENGTH: r_length <= i_cfg_data[LW-1:0];
                bsm_pkg::CFG_SEARCH_LIMIT:  r_limit  <= i_cfg_data[bsm_pkg::LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign used_len = (r_length > LW'(MAX_NEEDLE)) ? LW'(MAX_NEEDLE) : r_length;

    assign out_acc    = r_out_valid && !i_out_stall;
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign byte_step = in_acc && !i_in_word.end_of_string && !r_reported
                       && (used_len != '0);
    assign empty_hit = in_acc && !i_in_word.end_of_string && !r_reported
                       && (used_len == '0);
    assign term_res  = in_acc && i_in_word.end_of_string && !r_reported;

    assign cell_ctrl.shift = byte_step;
    assign cell_ctrl.clear = in_acc && i_in_word.end_of_string;

    // row of window cells, newest byte in cell 0
    assign chain[0] = i_in_word.text_byte;

    for (genvar gi = 0; gi < MAX_NEEDLE; gi++) begin : g_cell
        logic [LW-1:0] sel;
        assign sel = used_len - LW'(gi) - LW'(1);

        bsm_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (cell_ctrl),
            .i_byte        (chain[gi]),
            .i_needle_byte (r_needle[{sel[2:0], 3'b000} +: 8]),
            .i_active      (LW'(gi) < used_len),
            .o_byte        (chain[gi+1]),
            .o_hit         (hits[gi])
        );
    end

    // saturating byte count
    assign count_inc = (r_count == {CW{1'b1}}) ? r_count : r_count + CW'(1);

    assign match = byte_step && (count_inc >= CW'(used_len))
                   && (count_inc <= CW'(r_limit)) && (&hits);

    always_comb begin
        n_count    = r_count;
        n_reported = r_reported;
        if (cell_ctrl.clear) begin
            n_count    = '0;
            n_reported = 1'b0;
        end else begin
            if (byte_step) begin
                n_count = count_inc;
            end
            if (match || empty_hit) begin
                n_reported = 1'b1;
            end
        end
    end

    // output register
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;
        if (match || empty_hit || term_res) begin
            n_out_valid                = 1'b1;
            n_out_word.found           = match || empty_hit || (used_len == '0);
            n_out_word.match_position  = '0;
            if (match) begin
                n_out_word.match_position = 16'(count_inc - CW'(used_len));
            end
        end else if (out_acc) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_reported  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_reported  <= n_reported;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_word <= n_out_word;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire

>>> hw/rtl/bsm_checker.sv
// ----------------------------------------------------------------------------
// bsm_checker
// port-level checks for the bounded substring matcher
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bsm_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               o_in_stall,
    input  wire logic               o_out_valid,
    input  wire logic               i_out_stall,
    input  wire bsm_pkg::t_out_word o_out_word
);

    // a held result stays offered
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid)

    // input backs up only behind a full, stalled output register
    `ASSERT_CLK(a_stall_cause, i_clk, i_rst_n, o_in_stall |-> o_out_valid && i_out_stall)

    // a miss always reports position zero
    `ASSERT_CLK(a_miss_pos, i_clk, i_rst_n,
        o_out_valid && !o_out_word.found |-> o_out_word.match_position == '0)

    // a fresh result needs an accepted word just before it
    `ASSERT_CLK(a_result_src, i_clk, i_rst_n,
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall))

    // reset empties the output register
    `ASSERT_CLK_RST(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid)

endmodule

bind bounded_substring_matcher bsm_checker u_bsm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

`default_nettype wire
